>>> src/est_pkg.sv
// ----------------------------------------------------------------------------
// est_pkg
// Types, codes and fixed field widths shared by the event subscription table.
// ----------------------------------------------------------------------------
`default_nettype none

package est_pkg;

  localparam int unsigned TypeCountDefault   = 16;
  localparam int unsigned SubsPerTypeDefault = 8;
  localparam int unsigned IdWidthDefault     = 16;
  localparam int unsigned QueueDepth         = 2;

  localparam int unsigned TypeFieldWidth = 8;
  localparam int unsigned TaskFieldWidth = 16;
  localparam int unsigned InDataWidth    = 24;
  localparam int unsigned OutDataWidth   = 24;

  typedef enum logic [1:0] {
    OP_SUBSCRIBE   = 2'd0,
    OP_UNSUBSCRIBE = 2'd1,
    OP_FANOUT      = 2'd2,
    OP_RESERVED    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUP       = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_SCAN,
    BK_APPEND,
    BK_SHIFT,
    BK_FAN,
    BK_RESULT
  } back_state_e;

  typedef struct packed {
    op_e  op;
    logic bad;
  } cmd_ctl_t;

endpackage

`default_nettype wire

>>> src/est_front.sv
// ----------------------------------------------------------------------------
// est_front
// Input stage: accepts items, drops the unused operation and flags bad types.
// ----------------------------------------------------------------------------
`default_nettype none

module est_front #(
  parameter int unsigned TYPE_COUNT = est_pkg::TypeCountDefault,
  parameter int unsigned ID_WIDTH   = est_pkg::IdWidthDefault,
  parameter int unsigned TW         = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire est_pkg::op_e                        in_op_i,
  input  wire logic [est_pkg::TypeFieldWidth-1:0]  in_type_i,
  input  wire logic [est_pkg::TaskFieldWidth-1:0]  in_id_i,
  output logic                                     cmd_valid_o,
  input  wire logic                                cmd_ready_i,
  output est_pkg::cmd_ctl_t                        cmd_ctl_o,
  output logic [TW-1:0]                            cmd_type_o,
  output logic [ID_WIDTH-1:0]                      cmd_id_o
);
  import est_pkg::*;

  logic              vld_q, vld_d;
  cmd_ctl_t          ctl_q;
  logic [TW-1:0]     type_q;
  logic [ID_WIDTH-1:0] id_q;
  logic              in_fire;

  assign in_ready_o = !vld_q || cmd_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (vld_q && cmd_ready_i) begin
      vld_d = 1'b0;
    end
    if (in_fire && (in_op_i != OP_RESERVED)) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ctl_q.op  <= in_op_i;
      ctl_q.bad <= ({1'b0, in_type_i} >= 9'(TYPE_COUNT));
      type_q    <= in_type_i[TW-1:0];
      id_q      <= ID_WIDTH'(in_id_i);
    end
  end

  assign cmd_valid_o = vld_q;
  assign cmd_ctl_o   = ctl_q;
  assign cmd_type_o  = type_q;
  assign cmd_id_o    = id_q;

endmodule

`default_nettype wire

>>> src/est_queue.sv
// ----------------------------------------------------------------------------
// est_queue
// Short first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
`default_nettype none

module est_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = est_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);
  import est_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> src/est_back.sv
// ----------------------------------------------------------------------------
// est_back
// Execution stage: walks the subscriber lists and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module est_back #(
  parameter int unsigned TYPE_COUNT = est_pkg::TypeCountDefault,
  parameter int unsigned SPT        = est_pkg::SubsPerTypeDefault,
  parameter int unsigned ID_WIDTH   = est_pkg::IdWidthDefault,
  parameter int unsigned TW         = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cmd_valid_i,
  output logic                                     cmd_ready_o,
  input  wire est_pkg::cmd_ctl_t                   cmd_ctl_i,
  input  wire logic [TW-1:0]                       cmd_type_i,
  input  wire logic [ID_WIDTH-1:0]                 cmd_id_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output est_pkg::status_e                         out_status_o,
  output logic [est_pkg::TaskFieldWidth-1:0]       out_sub_o,
  output logic                                     out_has_o,
  output logic                                     out_last_o
);
  import est_pkg::*;

  localparam int unsigned MEM_DEPTH = TYPE_COUNT * SPT;
  localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned IW = $clog2(SPT + 1);
  localparam logic [AW-1:0] SptA = AW'(SPT);
  localparam logic [IW-1:0] SptI = IW'(SPT);

  logic [ID_WIDTH-1:0] mem [MEM_DEPTH];
  logic [IW-1:0]       count_q [TYPE_COUNT];

  back_state_e         state_q, state_d;
  op_e                 op_q, op_d;
  logic [TW-1:0]       type_q, type_d;
  logic [ID_WIDTH-1:0] id_q, id_d;
  logic [AW-1:0]       base_q, base_d;
  logic [IW-1:0]       n_q, n_d;
  logic [IW-1:0]       idx_q, idx_d, idx_nxt, rd_idx;
  status_e             status_q, status_d;
  logic [ID_WIDTH-1:0] rdata_q;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [ID_WIDTH-1:0] wr_data;
  logic                wr_en;
  logic                cnt_we;
  logic [IW-1:0]       cnt_wdata;
  logic                out_free, out_load;
  status_e             ld_status;
  logic [ID_WIDTH-1:0] ld_sub;
  logic                ld_has, ld_last;
  logic                out_vld_q;
  status_e             out_status_q;
  logic [TaskFieldWidth-1:0] out_sub_q;
  logic                out_has_q, out_last_q;
  logic                hit;

  assign out_free = !out_vld_q || out_ready_i;
  assign idx_nxt  = idx_q + 1'b1;
  assign hit      = (rdata_q == id_q);
  assign rd_idx   = (idx_d < SptI) ? idx_d : '0;
  assign rd_addr  = base_q + AW'(rd_idx);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    type_d      = type_q;
    id_d        = id_q;
    base_d      = base_q;
    n_d         = n_q;
    idx_d       = idx_q;
    status_d    = status_q;
    cmd_ready_o = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = base_q + AW'(n_q);
    wr_data     = id_q;
    cnt_we      = 1'b0;
    cnt_wdata   = n_q + 1'b1;
    out_load    = 1'b0;
    ld_status   = status_q;
    ld_sub      = '0;
    ld_has      = 1'b0;
    ld_last     = 1'b1;
    case (state_q)
      BK_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_d   = cmd_ctl_i.op;
          type_d = cmd_type_i;
          id_d   = cmd_id_i;
          base_d = AW'(cmd_type_i) * SptA;
          n_d    = cmd_ctl_i.bad ? '0 : count_q[cmd_type_i];
          if (cmd_ctl_i.bad) begin
            status_d = ST_BAD_TYPE;
            state_d  = BK_RESULT;
          end else begin
            state_d = BK_PREP;
          end
        end
      end
      BK_PREP: begin
        idx_d    = '0;
        status_d = ST_OK;
        case (op_q)
          OP_SUBSCRIBE: begin
            if (n_q >= SptI) begin
              status_d = ST_FULL;
              state_d  = BK_RESULT;
            end else if (n_q == '0) begin
              state_d = BK_APPEND;
            end else begin
              state_d = BK_SCAN;
            end
          end
          OP_UNSUBSCRIBE: begin
            if (n_q == '0) begin
              status_d = ST_NOT_FOUND;
              state_d  = BK_RESULT;
            end else begin
              state_d = BK_SCAN;
            end
          end
          default: begin
            state_d = (n_q == '0) ? BK_RESULT : BK_FAN;
          end
        endcase
      end
      BK_SCAN: begin
        if (hit && (op_q == OP_SUBSCRIBE)) begin
          status_d = ST_DUP;
          state_d  = BK_RESULT;
        end else if (hit) begin
          cnt_we    = 1'b1;
          cnt_wdata = n_q - 1'b1;
          status_d  = ST_OK;
          if (idx_nxt < n_q) begin
            idx_d   = idx_nxt;
            state_d = BK_SHIFT;
          end else begin
            state_d = BK_RESULT;
          end
        end else if (idx_nxt == n_q) begin
          if (op_q == OP_SUBSCRIBE) begin
            state_d = BK_APPEND;
          end else begin
            status_d = ST_NOT_FOUND;
            state_d  = BK_RESULT;
          end
        end else begin
          idx_d = idx_nxt;
        end
      end
      BK_APPEND: begin
        wr_en     = 1'b1;
        cnt_we    = 1'b1;
        cnt_wdata = n_q + 1'b1;
        status_d  = ST_OK;
        state_d   = BK_RESULT;
      end
      BK_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = base_q + AW'(idx_q - 1'b1);
        wr_data = rdata_q;
        if (idx_nxt < n_q) begin
          idx_d = idx_nxt;
        end else begin
          state_d = BK_RESULT;
        end
      end
      BK_FAN: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = ST_OK;
          ld_sub    = rdata_q;
          ld_has    = 1'b1;
          ld_last   = (idx_nxt == n_q);
          if (idx_nxt == n_q) begin
            state_d = BK_IDLE;
          end else begin
            idx_d = idx_nxt;
          end
        end
      end
      BK_RESULT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      out_vld_q <= 1'b0;
      for (int i = 0; i < TYPE_COUNT; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cnt_we) begin
        count_q[type_q] <= cnt_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    type_q   <= type_d;
    id_q     <= id_d;
    base_q   <= base_d;
    n_q      <= n_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    if (out_load) begin
      out_status_q <= ld_status;
      out_sub_q    <= TaskFieldWidth'(ld_sub);
      out_has_q    <= ld_has;
      out_last_q   <= ld_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_status_q;
  assign out_sub_o    = out_sub_q;
  assign out_has_o    = out_has_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

>>> src/event_subscription_table.sv
// ----------------------------------------------------------------------------
// event_subscription_table
// Per event type lists of subscribed task ids with subscribe, unsubscribe
// and fan-out commands.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel and results leave on m_axis.
// Subscribe and unsubscribe give one result with a status and tlast set.
// Fan-out gives one result per subscriber in list order, tlast on the final
// one, or a single result without a subscriber when the list is empty or the
// type is bad. The reserved operation code is taken and dropped.
// An item passes an input register and a two-entry queue before it reaches
// the execution engine. The engine loads it and prepares, then walks the
// list one entry per cycle through the id memory read port, and fan-out
// waits there while the result register is held; an append and the status
// result are steps of their own. Fan-out gives one result per cycle while
// the receiver takes them. One item is executed at a time. Reset empties
// every list at once; no clearing pass is needed. When the receiver stalls
// the result register holds, the engine waits and the queue and input
// register keep accepting until they are full.
// ----------------------------------------------------------------------------
`default_nettype none

module event_subscription_table #(
  parameter int unsigned TYPE_COUNT           = est_pkg::TypeCountDefault,
  parameter int unsigned SUBSCRIBERS_PER_TYPE = est_pkg::SubsPerTypeDefault,
  parameter int unsigned ID_WIDTH             = est_pkg::IdWidthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // evt_type [7:0], task_id [23:8]
  input  wire logic [est_pkg::InDataWidth-1:0]   s_axis_tdata,
  // operation [1:0]
  input  wire logic [1:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // status [2:0], subscriber [18:3], zero [23:19]
  output logic [est_pkg::OutDataWidth-1:0]       m_axis_tdata,
  // has_subscriber [0]
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast
);
  import est_pkg::*;

  localparam int unsigned TW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
  localparam int unsigned QW = $bits(cmd_ctl_t) + TW + ID_WIDTH;

  logic                 f_valid, f_ready;
  cmd_ctl_t             f_ctl;
  logic [TW-1:0]        f_type;
  logic [ID_WIDTH-1:0]  f_id;
  logic                 q_valid, q_ready;
  logic [QW-1:0]        q_data;
  cmd_ctl_t             q_ctl;
  logic [TW-1:0]        q_type;
  logic [ID_WIDTH-1:0]  q_id;
  status_e              r_status;
  logic [TaskFieldWidth-1:0] r_sub;
  logic                 r_has;

  est_front #(
    .TYPE_COUNT (TYPE_COUNT),
    .ID_WIDTH   (ID_WIDTH),
    .TW         (TW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (op_e'(s_axis_tuser)),
    .in_type_i   (s_axis_tdata[7:0]),
    .in_id_i     (s_axis_tdata[23:8]),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_ctl_o   (f_ctl),
    .cmd_type_o  (f_type),
    .cmd_id_o    (f_id)
  );

  est_queue #(
    .WIDTH (QW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_ctl, f_type, f_id}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  assign {q_ctl, q_type, q_id} = q_data;

  est_back #(
    .TYPE_COUNT (TYPE_COUNT),
    .SPT        (SUBSCRIBERS_PER_TYPE),
    .ID_WIDTH   (ID_WIDTH),
    .TW         (TW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_ready_o  (q_ready),
    .cmd_ctl_i    (q_ctl),
    .cmd_type_i   (q_type),
    .cmd_id_i     (q_id),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (r_status),
    .out_sub_o    (r_sub),
    .out_has_o    (r_has),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, r_sub, r_status};
  assign m_axis_tuser = r_has;

`ifndef SYNTHESIS
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("result without subscriber is not marked last");

  a_empty_sub_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[18:3] == '0))
    else $error("subscriber field not zero on result without subscriber");

  a_sub_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[2:0] == ST_OK))
    else $error("fan-out result carries a failure status");
`endif

endmodule

`default_nettype wire

>>> test/event_subscription_table_tb.sv
// ----------------------------------------------------------------------------
// event_subscription_table_tb
// Self-checking bench for the per event type subscriber lists.
// A short table of directed commands covers reset, bad types, full and
// duplicate cases, removal at the head, middle and tail, and the reserved
// code. Random commands follow: mostly valid types and reused task ids, so
// that lists fill, empty and shift. A local copy of the lists predicts every
// result item, and each item leaving the block is compared with the oldest
// prediction. Both sides idle at random, and once the receiver holds off
// long enough for the input to stall.
// ----------------------------------------------------------------------------
`default_nettype none

module event_subscription_table_tb;
  import est_pkg::*;

  localparam int unsigned TYPES       = TypeCountDefault;
  localparam int unsigned SLOTS       = SubsPerTypeDefault;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned RAND_ITEMS  = 350;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN       = 40;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    status_e     status;
    logic [15:0] subscriber;
    logic        has_sub;
    logic        last;
  } sub_result_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  etype;
    logic [15:0] tid;
    logic        typed;
    status_e     status;
  } stim_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata;
  logic [1:0]              s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    m_axis_tlast;

  logic [15:0]   ids_model [TYPES][SLOTS];
  int unsigned   count_model [TYPES];
  sub_result_t   predicted_q [$];
  sub_result_t   awaited_results [$];
  stim_row_t     directed_rows [ROWS];
  logic [15:0]   id_pool [12];

  int unsigned   cycle_count;
  int unsigned   mismatches;
  int unsigned   items_sent;
  int unsigned   results_seen;
  int unsigned   fanout_entries;
  int unsigned   status_seen [5];
  bit            steady;
  bit            hold_req;
  int unsigned   hold_left;
  int unsigned   stall_left;

  event_subscription_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d result items outstanding",
               cycle_count, awaited_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Applies one command to the local lists and leaves its result items in
  // predicted_q.
  function automatic void predict_table_op(op_e op, logic [7:0] etype,
                                           logic [15:0] tid);
    sub_result_t r;
    int unsigned n;
    int unsigned pos;
    bit          found;
    predicted_q.delete();
    if (op == OP_RESERVED) return;
    r = '{status: ST_OK, subscriber: 16'h0, has_sub: 1'b0, last: 1'b1};
    if (etype >= TYPES) begin
      r.status = ST_BAD_TYPE;
    end else begin
      n = count_model[etype];
      case (op)
        OP_SUBSCRIBE: begin
          found = 1'b0;
          for (int i = 0; i < n; i++) if (ids_model[etype][i] == tid) found = 1'b1;
          if (n >= SLOTS) begin
            r.status = ST_FULL;
          end else if (found) begin
            r.status = ST_DUP;
          end else begin
            ids_model[etype][n] = tid;
            count_model[etype]  = n + 1;
          end
        end
        OP_UNSUBSCRIBE: begin
          pos = n;
          for (int i = 0; i < n; i++) if (pos == n && ids_model[etype][i] == tid) pos = i;
          if (pos == n) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (int j = pos; j + 1 < n; j++) ids_model[etype][j] = ids_model[etype][j + 1];
            count_model[etype] = n - 1;
          end
        end
        default: begin
          for (int i = 0; i < n; i++) begin
            predicted_q.push_back('{status: ST_OK, subscriber: ids_model[etype][i],
                                    has_sub: 1'b1, last: (i + 1 == n)});
          end
          if (n > 0) return;
        end
      endcase
    end
    predicted_q.push_back(r);
  endfunction

  task automatic offer_item(op_e op, logic [7:0] etype, logic [15:0] tid,
                            logic typed, status_e tstat);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {tid, etype};
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_table_op(op, etype, tid);
    if (typed) begin
      awaited_results.push_back('{status: tstat, subscriber: 16'h0, has_sub: 1'b0,
                                  last: 1'b1});
    end else begin
      foreach (predicted_q[k]) awaited_results.push_back(predicted_q[k]);
    end
    items_sent++;
  endtask

  // Receiver: random stalls, calm stretches and one long hold-off.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req      = 1'b0;
        hold_left     = HOLD_CYCLES - 1;
        m_axis_tready = 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        stall_left    = pick_gap();
        m_axis_tready = (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    sub_result_t want;
    status_e     got_status;
    logic [15:0] got_sub;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      got_status = status_e'(m_axis_tdata[2:0]);
      got_sub    = m_axis_tdata[18:3];
      if (m_axis_tdata[2:0] < 5) status_seen[m_axis_tdata[2:0]]++;
      if (m_axis_tuser) fanout_entries++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result item: status %0d subscriber %h has %b last %b",
                   m_axis_tdata[2:0], got_sub, m_axis_tuser, m_axis_tlast);
      end else begin
        want = awaited_results.pop_front();
        if (got_status != want.status || got_sub != want.subscriber ||
            m_axis_tdata[23:19] != 5'b0 || m_axis_tuser != want.has_sub ||
            m_axis_tlast != want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at cycle %0d: expected status %0d subscriber %h has %b last %b,",
                     cycle_count, want.status, want.subscriber, want.has_sub, want.last);
            $display("  got status %0d subscriber %h pad %h has %b last %b",
                     m_axis_tdata[2:0], got_sub, m_axis_tdata[23:19], m_axis_tuser,
                     m_axis_tlast);
          end
        end
      end
    end
  end

  initial begin
    op_e         op;
    logic [7:0]  etype;
    logic [15:0] tid;
    int unsigned r;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    stall_left    = 0;
    foreach (count_model[t]) count_model[t] = 0;
    foreach (status_seen[s]) status_seen[s] = 0;

    directed_rows = '{
      '{OP_FANOUT,      8'd0,   16'h0000, 1'b1, ST_OK},
      '{OP_FANOUT,      8'd255, 16'h0000, 1'b1, ST_BAD_TYPE},
      '{OP_SUBSCRIBE,   8'd16,  16'hFFFF, 1'b1, ST_BAD_TYPE},
      '{OP_UNSUBSCRIBE, 8'd200, 16'h0001, 1'b1, ST_BAD_TYPE},
      '{OP_UNSUBSCRIBE, 8'd0,   16'h0005, 1'b1, ST_NOT_FOUND},
      '{OP_SUBSCRIBE,   8'd0,   16'h0000, 1'b1, ST_OK},
      '{OP_SUBSCRIBE,   8'd0,   16'h0000, 1'b1, ST_DUP},
      '{OP_SUBSCRIBE,   8'd0,   16'hFFFF, 1'b0, ST_OK},
      '{OP_SUBSCRIBE,   8'd0,   16'hA5A5, 1'b0, ST_OK},
      '{OP_SUBSCRIBE,   8'd0,   16'h5A5A, 1'b0, ST_OK},
      '{OP_SUBSCRIBE,   8'd0,   16'h0001, 1'b0, ST_OK},
      '{OP_SUBSCRIBE,   8'd0,   16'h0002, 1'b0, ST_OK},
      '{OP_SUBSCRIBE,   8'd0,   16'h0003, 1'b0, ST_OK},
      '{OP_SUBSCRIBE,   8'd0,   16'h0004, 1'b0, ST_OK},
      '{OP_SUBSCRIBE,   8'd0,   16'h1234, 1'b1, ST_FULL},
      '{OP_SUBSCRIBE,   8'd0,   16'hFFFF, 1'b1, ST_FULL},
      '{OP_FANOUT,      8'd0,   16'hFFFF, 1'b0, ST_OK},
      '{OP_UNSUBSCRIBE, 8'd0,   16'h0000, 1'b0, ST_OK},
      '{OP_UNSUBSCRIBE, 8'd0,   16'h0004, 1'b0, ST_OK},
      '{OP_UNSUBSCRIBE, 8'd0,   16'h5A5A, 1'b0, ST_OK},
      '{OP_FANOUT,      8'd0,   16'h0000, 1'b0, ST_OK},
      '{OP_RESERVED,    8'd0,   16'h0000, 1'b0, ST_OK},
      '{OP_SUBSCRIBE,   8'd15,  16'h8000, 1'b1, ST_OK},
      '{OP_FANOUT,      8'd15,  16'h0000, 1'b0, ST_OK},
      '{OP_RESERVED,    8'd255, 16'hFFFF, 1'b0, ST_OK}
    };
    foreach (id_pool[p]) id_pool[p] = (p < 4) ? 16'(p) : 16'($urandom_range(0, 65535));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[k])
      offer_item(directed_rows[k].op, directed_rows[k].etype, directed_rows[k].tid,
                 directed_rows[k].typed, directed_rows[k].status);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 2) == 0);
      if (i == 120) begin
        steady   = 1'b0;
        hold_req = 1'b1;
      end
      r     = $urandom_range(0, 99);
      etype = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, TYPES - 1));
      tid   = ($urandom_range(0, 9) < 7) ? id_pool[$urandom_range(0, 11)]
                                         : 16'($urandom_range(0, 65535));
      if (r < 40) begin
        op = OP_SUBSCRIBE;
      end else if (r < 65) begin
        op = OP_UNSUBSCRIBE;
      end else if (r < 88) begin
        op = OP_FANOUT;
      end else if (r < 94) begin
        op    = OP_RESERVED;
        etype = 8'($urandom_range(0, 255));
      end else begin
        op    = op_e'($urandom_range(0, 2));
        etype = 8'($urandom_range(TYPES, 255));
      end
      offer_item(op, etype, tid, 1'b0, ST_OK);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("Covered %0d command items (%0d from the table) and %0d result items,",
             items_sent, ROWS, results_seen);
    $display("%0d fan-out entries; ok %0d, bad type %0d, full %0d, duplicate %0d, missing %0d.",
             fanout_entries, status_seen[0], status_seen[1], status_seen[2],
             status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
